@@ sv/event_cut_weighted_histogram_macros.svh @@
`ifndef EVENT_CUT_WEIGHTED_HISTOGRAM_MACROS_SVH
`define EVENT_CUT_WEIGHTED_HISTOGRAM_MACROS_SVH
// implication checked on every clock edge outside reset
`define ECWH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ecwh check failed");
// implication checked in the cycle after the antecedent
`define ECWH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ecwh check failed");
`endif

@@ sv/ecwh_pkg.sv @@
package ecwh_pkg;
  localparam int NumBins = 64;
  localparam int BinW = $clog2(NumBins);
  localparam int SumW = 48;
  localparam int ScaleW = 56;
  localparam int RateW = 64;
  localparam logic [SumW-1:0] SumMax = '1;
  localparam logic [31:0] OneWeight = 32'h0001_0000;

  localparam logic [2:0] RegUnbinned = 3'd0;
  localparam logic [2:0] RegCuts = 3'd1;
  localparam logic [2:0] RegMinE = 3'd2;
  localparam logic [2:0] RegMaxE = 3'd3;
  localparam logic [2:0] RegMinCos = 3'd4;
  localparam logic [2:0] RegMaxTime = 3'd5;
  localparam logic [2:0] RegBinWidth = 3'd6;
  localparam logic [2:0] RegScale = 3'd7;

  localparam logic [1:0] KindEvent = 2'd0;
  localparam logic [1:0] KindBin = 2'd1;
  localparam logic [1:0] KindEmpty = 2'd2;

  typedef struct packed {
    logic start;
    logic [SumW-1:0] a;
  } mul_req_t;
endpackage

@@ sv/ecwh_div.sv @@
module ecwh_div import ecwh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [23:0] quo_o
);
  logic [23:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic [4:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [16:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[15:0], quo_q[23]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = (den_i == '0) ? 16'd1 : den_i;
      cnt_d = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[22:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = 16'(trial - {1'b0, den_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[15:0];
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

@@ sv/ecwh_mul.sv @@
module ecwh_mul import ecwh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mul_req_t          req_i,
  input  logic [ScaleW-1:0] scale_i,
  output logic              done_o,
  output logic [RateW-1:0]  rate_o
);
  // 48x56 product by 16-bit digits of a, one per cycle
  logic [SumW-1:0] a_q, a_d;
  logic [103:0] acc_q, acc_d;
  logic [1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [71:0] pp;

  assign pp = a_q[15:0] * scale_i;

  always_comb begin
    a_d = a_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d = req_i.a;
      acc_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {16'd0, acc_q[103:16]} + {pp, 32'd0};
      a_d = {16'd0, a_q[SumW-1:16]};
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd2) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign rate_o = (acc_q[103:88] != '0) ? '1 : acc_q[87:24];
endmodule

@@ sv/event_cut_weighted_histogram.sv @@
// channel | direction | handshake            | payload
// request | in        | in_valid_i/in_ready_o | operation_i .. event_weight_i
// result  | out       | out_valid_o/out_ready_i | kind_o .. last_o
// config  | in        | cfg_we_i              | cfg_index_i, cfg_data_i
// Binned event: from accept, 24 radix-2 divider steps, the registered quotient seen in
// S_DIV, then one bin read-modify-write (skipped when the bin is out of range).
// Unbinned event: goes through the 3-step 16x56 multiplier, then the result waits.
// Flush: scan of up to 64 bins, S_RD, S_BMUL per non-empty bin, each result held until
// taken; nonzero flags clear as bins are read, overflow clears with the final result.
// Reset clears control, nonzero flags and overflow at once; no clearing pass.
// A stalled result holds the sequencer; the request side stays not ready.
`include "event_cut_weighted_histogram_macros.svh"
module event_cut_weighted_histogram import ecwh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [23:0]       energy_i,
  input  logic              has_direction_i,
  input  logic signed [15:0] direction_cosine_i,
  input  logic              has_time_i,
  input  logic signed [31:0] arrival_time_i,
  input  logic              has_weight_i,
  input  logic [31:0]       event_weight_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [5:0]        bin_index_o,
  output logic [24:0]       energy_out_o,
  output logic [63:0]       rate_o,
  output logic              overflow_seen_o,
  output logic              last_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [55:0]       cfg_data_i
);
  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_RMW, S_MUL, S_OUT, S_SCAN, S_RD, S_BMUL
  } state_e;

  state_e state_q;
  logic unbinned_q;
  logic [3:0] cuts_q;
  logic [23:0] min_e_q, max_e_q;
  logic signed [15:0] min_cos_q;
  logic signed [31:0] max_time_q;
  logic [15:0] bin_width_q;
  logic [ScaleW-1:0] scale_q;

  logic [SumW-1:0] sums_q [NumBins];
  logic [NumBins-1:0] vld_q;
  logic ovf_q;
  logic [23:0] e_q;
  logic [31:0] w_q;
  logic [BinW:0] idx_q;
  logic any_q;
  logic [SumW-1:0] rd_q;

  logic out_valid_q, flush_q;
  logic [1:0] kind_q;
  logic [5:0] bin_q;
  logic [24:0] eo_q;
  logic [RateW-1:0] rate_q;
  logic ovf_out_q, last_q;

  logic div_done, mul_done;
  logic [23:0] quo;
  logic [RateW-1:0] mul_rate;
  mul_req_t mreq;
  logic in_acc, rejected;
  logic [48:0] sum_ext;
  logic [BinW-1:0] bi;
  logic [BinW:0] next_nz;
  logic [BinW-1:0] raddr;
  logic [SumW-1:0] wdata;
  logic [NumBins-1:0] vld_rest;

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc = in_valid_i && in_ready_o;
  assign rejected = (cuts_q[0] && energy_i < min_e_q) || (cuts_q[1] && energy_i > max_e_q)
      || (cuts_q[2] && has_direction_i && direction_cosine_i < min_cos_q)
      || (cuts_q[3] && has_time_i && arrival_time_i > max_time_q);
  assign bi = quo[BinW-1:0];
  assign sum_ext = {1'b0, (vld_q[bi] ? rd_q : {SumW{1'b0}})} + {17'd0, w_q};
  assign wdata = sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
  assign raddr = (state_q == S_SCAN) ? idx_q[BinW-1:0] : bi;

  always_comb begin
    vld_rest = vld_q;
    vld_rest[idx_q[BinW-1:0]] = 1'b0;
  end

  always_comb begin
    mreq.start = 1'b0;
    mreq.a = '0;
    if (in_acc && !operation_i && !rejected && unbinned_q) begin
      mreq.start = 1'b1;
      mreq.a = {16'd0, has_weight_i ? event_weight_i : OneWeight};
    end else if (state_q == S_RD) begin
      mreq.start = 1'b1;
      mreq.a = rd_q;
    end
  end

  ecwh_div u_div (
    .clk_i, .rst_ni,
    .start_i(in_acc && !operation_i && !rejected && !unbinned_q),
    .num_i(energy_i), .den_i(bin_width_q),
    .done_o(div_done), .quo_o(quo)
  );

  ecwh_mul u_mul (
    .clk_i, .rst_ni, .req_i(mreq), .scale_i(scale_q),
    .done_o(mul_done), .rate_o(mul_rate)
  );

  assign next_nz = idx_q + 7'd1;

  always_ff @(posedge clk_i) begin
    if (state_q == S_RMW) begin
      sums_q[bi] <= wdata;
    end
    rd_q <= sums_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      unbinned_q <= 1'b0;
      cuts_q <= '0;
      min_e_q <= '0;
      max_e_q <= 24'hFF_FFFF;
      min_cos_q <= 16'sh8000;
      max_time_q <= 32'sh7FFF_FFFF;
      bin_width_q <= 16'd256;
      scale_q <= 56'd256;
      vld_q <= '0;
      ovf_q <= 1'b0;
      out_valid_q <= 1'b0;
      flush_q <= 1'b0;
      idx_q <= '0;
      any_q <= 1'b0;
      e_q <= '0;
      w_q <= '0;
      kind_q <= KindEvent;
      bin_q <= '0;
      eo_q <= '0;
      rate_q <= '0;
      ovf_out_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegUnbinned: unbinned_q <= cfg_data_i[0];
          RegCuts: cuts_q <= cfg_data_i[3:0];
          RegMinE: min_e_q <= cfg_data_i[23:0];
          RegMaxE: max_e_q <= cfg_data_i[23:0];
          RegMinCos: min_cos_q <= cfg_data_i[15:0];
          RegMaxTime: max_time_q <= cfg_data_i[31:0];
          RegBinWidth: bin_width_q <= cfg_data_i[15:0];
          RegScale: scale_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            e_q <= energy_i;
            w_q <= has_weight_i ? event_weight_i : OneWeight;
            if (operation_i) begin
              state_q <= S_SCAN;
              idx_q <= '0;
              any_q <= 1'b0;
            end else if (!rejected) begin
              state_q <= unbinned_q ? S_MUL : S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (quo >= 24'(NumBins)) begin
              ovf_q <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_RMW;
            end
          end
        end
        S_RMW: begin
          vld_q[bi] <= vld_q[bi] | (wdata != '0);
          state_q <= S_IDLE;
        end
        S_MUL: begin
          if (mul_done) begin
            out_valid_q <= 1'b1;
            kind_q <= KindEvent;
            bin_q <= '0;
            eo_q <= {e_q, 1'b0};
            rate_q <= mul_rate;
            ovf_out_q <= ovf_q;
            last_q <= 1'b0;
            state_q <= S_OUT;
            flush_q <= 1'b0;
          end
        end
        S_OUT: begin
          if (out_valid_q && out_ready_i) begin
            if (flush_q && !last_q) begin
              state_q <= S_SCAN;
            end else begin
              state_q <= S_IDLE;
              if (flush_q) begin
                ovf_q <= 1'b0;
              end
            end
          end
        end
        S_SCAN: begin
          if (idx_q[BinW]) begin
            vld_q <= '0;
            ovf_q <= 1'b0;
            state_q <= S_IDLE;
            if (!any_q) begin
              out_valid_q <= 1'b1;
              kind_q <= KindEmpty;
              bin_q <= '0;
              eo_q <= '0;
              rate_q <= '0;
              ovf_out_q <= ovf_q;
              last_q <= 1'b1;
            end else begin
              last_q <= 1'b1;
            end
          end else if (vld_q[idx_q[BinW-1:0]]) begin
            state_q <= S_RD;
          end else begin
            idx_q <= next_nz;
          end
        end
        S_RD: begin
          state_q <= S_BMUL;
        end
        S_BMUL: begin
          if (mul_done) begin
            any_q <= 1'b1;
            kind_q <= KindBin;
            bin_q <= idx_q[BinW-1:0];
            eo_q <= 25'({idx_q[BinW-1:0], 1'b1}) * 25'(bin_width_q);
            rate_q <= mul_rate;
            ovf_out_q <= ovf_q;
            last_q <= (vld_rest == '0);
            vld_q <= vld_rest;
            idx_q <= next_nz;
            flush_q <= 1'b1;
            state_q <= S_OUT;
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o = kind_q;
  assign bin_index_o = bin_q;
  assign energy_out_o = eo_q;
  assign rate_o = rate_q;
  assign overflow_seen_o = ovf_out_q;
  assign last_o = last_q;

  `ECWH_ASSERT_IMP(a_ready_idle, in_ready_o, state_q == S_IDLE && !out_valid_q)
  `ECWH_ASSERT_NEXT(a_rmw_done, state_q == S_RMW, state_q == S_IDLE)
  `ECWH_ASSERT_IMP(a_empty_last, out_valid_o && kind_o == KindEmpty, last_o)
  `ECWH_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(rate_o))
endmodule
